>>> hw/rtl/serial_command_word_matcher_assert.svh
// Assertion macros shared by the serial command word matcher RTL
`ifndef SERIAL_COMMAND_WORD_MATCHER_ASSERT_SVH
`define SERIAL_COMMAND_WORD_MATCHER_ASSERT_SVH

// Property must hold at every clock edge outside reset
`define SCWM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true outside reset
`define SCWM_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

>>> hw/rtl/scwm_pkg.sv
// Shared types and constants of the serial command word matcher
package scwm_pkg;

  localparam int TableEntries = 6;
  localparam int NameChars    = 8;
  localparam int QueueDepth   = 2;

  localparam int MaxLenW   = 10;
  localparam int CmdCountW = 3;
  localparam int NameW     = 64;
  localparam int StoredW   = 11;
  localparam int WordLenW  = 4;
  localparam int IndexW    = 3;
  localparam int RegIndexW = 3;

  // Register indexes of the configuration port
  localparam logic [RegIndexW-1:0] REG_MAX_LENGTH    = 3'd0;
  localparam logic [RegIndexW-1:0] REG_COMMAND_COUNT = 3'd1;
  localparam logic [RegIndexW-1:0] REG_NAME_FIRST    = 3'd2;

  localparam logic [MaxLenW-1:0]   MAX_LENGTH_RESET  = 10'd64;

  // Characters with a meaning on the line
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef enum logic [1:0] {
    ST_BUSY     = 2'd0,
    ST_NOT_CMD  = 2'd1,
    ST_MAX_SIZE = 2'd2,
    ST_MATCHED  = 2'd3
  } status_t;

  // One received word after classification
  typedef struct packed {
    logic [7:0] ch;
    logic       is_lf;
    logic       is_cr;
    logic       is_space;
    logic       is_nul;
  } rx_word_t;

endpackage

>>> hw/rtl/scwm_front.sv
// Front stage: accepts received words and classifies them
module scwm_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_rx_byte,
  output logic              push_valid,
  input  logic              push_ready,
  output scwm_pkg::rx_word_t push_word
);
  import scwm_pkg::*;

  logic     hold_valid_r;
  rx_word_t hold_word_r;
  rx_word_t cls_word;

  // Classify the incoming character
  always_comb begin
    cls_word.ch       = in_rx_byte;
    cls_word.is_lf    = (in_rx_byte == CH_LF);
    cls_word.is_cr    = (in_rx_byte == CH_CR);
    cls_word.is_space = (in_rx_byte == CH_SPACE);
    cls_word.is_nul   = (in_rx_byte == CH_NUL);
  end

  // Take a new word whenever the held one leaves or the stage is empty
  assign in_ready   = !hold_valid_r || push_ready;
  assign push_valid = hold_valid_r;
  assign push_word  = hold_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (in_ready) begin
      hold_valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      hold_word_r <= cls_word;
    end
  end

endmodule

>>> hw/rtl/scwm_queue.sv
// Short queue between the front and back stages
module scwm_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  scwm_pkg::rx_word_t push_word,
  output logic               pop_valid,
  input  logic               pop_ready,
  output scwm_pkg::rx_word_t pop_word
);
  import scwm_pkg::*;
  `include "serial_command_word_matcher_assert.svh"

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);
  localparam logic [CntW-1:0] Full = CntW'(QueueDepth);

  rx_word_t        entries_r [QueueDepth];
  logic [PtrW-1:0] wr_ptr_r;
  logic [PtrW-1:0] rd_ptr_r;
  logic [CntW-1:0] count_r;
  logic            push;
  logic            pop;

  assign push_ready = (count_r != Full);
  assign pop_valid  = (count_r != '0);
  assign pop_word   = entries_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Store pushed words
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_word;
    end
  end

  `SCWM_NEVER(a_queue_count_range, count_r > Full, "queue occupancy beyond depth")

endmodule

>>> hw/rtl/scwm_back.sv
// Back stage: line state, on-the-fly name compare and result register
module scwm_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [scwm_pkg::RegIndexW-1:0]    cfg_index,
  input  logic [scwm_pkg::NameW-1:0]        cfg_data,
  input  logic                              pop_valid,
  output logic                              pop_ready,
  input  scwm_pkg::rx_word_t                pop_word,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_status,
  output logic [scwm_pkg::IndexW-1:0]       out_command_index
);
  import scwm_pkg::*;
  `include "serial_command_word_matcher_assert.svh"

  typedef enum logic [1:0] {
    PH_SKIP = 2'd0,
    PH_WORD = 2'd1,
    PH_DONE = 2'd2
  } phase_t;

  localparam logic [WordLenW-1:0] WlFull = WordLenW'(NameChars);
  localparam logic [WordLenW-1:0] WlSat  = WordLenW'(NameChars + 1);

  // Configuration registers
  logic [MaxLenW-1:0]   max_length_r;
  logic [CmdCountW-1:0] command_count_r;
  logic [NameW-1:0]     names_r [TableEntries];

  // Line state
  logic [StoredW-1:0]      stored_count_r, stored_count_nxt;
  phase_t                  phase_r, phase_nxt;
  logic [WordLenW-1:0]     word_length_r, word_length_nxt;
  logic [TableEntries-1:0] match_mask_r, match_mask_nxt;

  // Result register
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [IndexW-1:0] out_index_r, out_index_nxt;

  logic                    pop;
  logic [CmdCountW-1:0]    n_eff;
  logic [TableEntries-1:0] hit;
  logic [TableEntries-1:0] keep;
  logic [7:0]              name_ch [TableEntries];
  logic                    any_hit;
  logic [IndexW-1:0]       hit_index;

  assign pop_ready = !out_valid_r || out_ready;
  assign pop       = pop_valid && pop_ready;

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_command_index = out_index_r;

  assign n_eff = (command_count_r > CmdCountW'(TableEntries)) ?
                 CmdCountW'(TableEntries) : command_count_r;

  // Compare every entry at the current word position
  always_comb begin
    for (int i = 0; i < TableEntries; i++) begin
      name_ch[i] = names_r[i][{word_length_r[2:0], 3'b000} +: 8];
      if (word_length_r >= WlFull) begin
        hit[i] = match_mask_r[i] && (word_length_r == WlFull);
      end else begin
        hit[i] = match_mask_r[i] && (name_ch[i] == CH_NUL);
      end
      hit[i] = hit[i] && (CmdCountW'(i) < n_eff);
      keep[i] = (word_length_r < WlFull) && !pop_word.is_nul &&
                (name_ch[i] == pop_word.ch);
    end
  end

  // Pick the lowest matching entry
  always_comb begin
    any_hit   = |hit;
    hit_index = '0;
    for (int i = TableEntries - 1; i >= 0; i--) begin
      if (hit[i]) begin
        hit_index = IndexW'(i);
      end
    end
  end

  // Next line state and result
  always_comb begin
    stored_count_nxt = stored_count_r;
    phase_nxt        = phase_r;
    word_length_nxt  = word_length_r;
    match_mask_nxt   = match_mask_r;
    out_valid_nxt    = out_valid_r;
    out_status_nxt   = out_status_r;
    out_index_nxt    = out_index_r;
    if (pop) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = ST_BUSY;
      out_index_nxt  = '0;
      if (pop_word.is_lf) begin
        // End of line: report and restart
        out_status_nxt   = any_hit ? ST_MATCHED : ST_NOT_CMD;
        out_index_nxt    = any_hit ? hit_index : '0;
        stored_count_nxt = '0;
        phase_nxt        = PH_SKIP;
        word_length_nxt  = '0;
        match_mask_nxt   = '1;
      end else if (stored_count_r > StoredW'(max_length_r)) begin
        // Overflow: drop the word and clear the line
        out_status_nxt   = ST_MAX_SIZE;
        stored_count_nxt = '0;
        phase_nxt        = PH_SKIP;
        word_length_nxt  = '0;
        match_mask_nxt   = '1;
      end else if (!pop_word.is_cr) begin
        stored_count_nxt = stored_count_r + 1'b1;
        unique case (phase_r)
          PH_SKIP: begin
            if (!pop_word.is_space) begin
              phase_nxt       = PH_WORD;
              match_mask_nxt  = match_mask_r & keep;
              word_length_nxt = (word_length_r < WlSat) ? word_length_r + 1'b1 : word_length_r;
            end
          end
          PH_WORD: begin
            if (pop_word.is_space) begin
              phase_nxt = PH_DONE;
            end else begin
              match_mask_nxt  = match_mask_r & keep;
              word_length_nxt = (word_length_r < WlSat) ? word_length_r + 1'b1 : word_length_r;
            end
          end
          PH_DONE: begin
            phase_nxt = PH_DONE;
          end
          default: begin
            phase_nxt = PH_DONE;
          end
        endcase
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Hold line state and the registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stored_count_r <= '0;
      phase_r        <= PH_SKIP;
      word_length_r  <= '0;
      match_mask_r   <= '1;
      out_valid_r    <= 1'b0;
    end else begin
      stored_count_r <= stored_count_nxt;
      phase_r        <= phase_nxt;
      word_length_r  <= word_length_nxt;
      match_mask_r   <= match_mask_nxt;
      out_valid_r    <= out_valid_nxt;
    end
    out_status_r <= out_status_nxt;
    out_index_r  <= out_index_nxt;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_length_r    <= MAX_LENGTH_RESET;
      command_count_r <= '0;
      for (int i = 0; i < TableEntries; i++) begin
        names_r[i] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == REG_MAX_LENGTH) begin
        max_length_r <= cfg_data[MaxLenW-1:0];
      end else if (cfg_index == REG_COMMAND_COUNT) begin
        command_count_r <= cfg_data[CmdCountW-1:0];
      end else begin
        for (int i = 0; i < TableEntries; i++) begin
          if (cfg_index == RegIndexW'(i + REG_NAME_FIRST)) begin
            names_r[i] <= cfg_data;
          end
        end
      end
    end
  end

  `SCWM_ASSERT(a_match_in_table, (out_valid_r && out_status_r == ST_MATCHED) |-> (out_index_r < n_eff), "matched entry outside the table")
  `SCWM_ASSERT(a_overflow_clears, (out_valid_r && out_status_r == ST_MAX_SIZE && $rose(out_valid_r)) |-> (stored_count_r == '0), "overflow left the line count set")
  `SCWM_NEVER(a_word_len_sat, word_length_r > WlSat, "word length past saturation")

endmodule

>>> hw/rtl/serial_command_word_matcher.sv
// Top level of the serial command word matcher
//
//  Channel   Direction  Handshake              Payload
//  in_       input      in_valid / in_ready    in_rx_byte
//  out_      output     out_valid / out_ready  out_status, out_command_index
//  cfg_      input      cfg_we                 cfg_index, cfg_data
//
// One received word per cycle sustained while the output is not stalled; a taken word loads
// the front register, passes through the queue, and its status loads the result register.
// The back stage updates the line state and compares all table entries at once.
// rst_n (synchronous) restores the register reset values and an empty line.
// A stalled output fills the queue, then the front register, then drops in_ready.
module serial_command_word_matcher (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_rx_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     out_status,
  output logic [scwm_pkg::IndexW-1:0]    out_command_index,
  input  logic                           cfg_we,
  input  logic [scwm_pkg::RegIndexW-1:0] cfg_index,
  input  logic [scwm_pkg::NameW-1:0]     cfg_data
);
  import scwm_pkg::*;

  logic     f_valid;
  logic     f_ready;
  rx_word_t f_word;
  logic     q_valid;
  logic     q_ready;
  rx_word_t q_word;

  scwm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_word  (f_word)
  );

  scwm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_word  (f_word),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_word   (q_word)
  );

  scwm_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .pop_valid         (q_valid),
    .pop_ready         (q_ready),
    .pop_word          (q_word),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_command_index (out_command_index)
  );

endmodule

>>> sim/serial_command_word_matcher_tb.sv
// Self-checking testbench of the serial command word matcher: table-driven and random lines
module serial_command_word_matcher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import scwm_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int RANDOM_PHASES   = 6;
  localparam int WORDS_PER_PHASE = 283;
  localparam int DRAIN_CYCLES    = 8;

  typedef enum logic [1:0] {
    PH_LEAD = 2'd0,
    PH_WORD = 2'd1,
    PH_DONE = 2'd2
  } token_phase_t;

  typedef struct packed {
    status_t             st;
    logic [IndexW-1:0]   idx;
  } line_status_t;

  typedef enum logic {
    ROW_REG  = 1'b0,
    ROW_CHAR = 1'b1
  } row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [RegIndexW-1:0]   reg_idx;
    logic [NameW-1:0]       data;
    logic                   fixed;
    status_t                st;
    logic [IndexW-1:0]      idx;
  } directed_row_t;

  // Directed table: register writes and words; fixed rows carry their own expectation
  localparam directed_row_t DIRECTED_ROWS [34] = '{
    '{ROW_CHAR, '0, 64'h0A, 1'b1, ST_NOT_CMD, 3'd0},   // empty table after reset
    '{ROW_REG, REG_MAX_LENGTH, 64'd3, 1'b0, ST_BUSY, 3'd0},
    '{ROW_REG, REG_COMMAND_COUNT, 64'd7, 1'b0, ST_BUSY, 3'd0},
    '{ROW_REG, REG_NAME_FIRST + 3'd0, 64'h6261, 1'b0, ST_BUSY, 3'd0},  // "ab"
    '{ROW_REG, REG_NAME_FIRST + 3'd1, 64'h6261, 1'b0, ST_BUSY, 3'd0},  // "ab" again
    '{ROW_REG, REG_NAME_FIRST + 3'd2, 64'h0, 1'b0, ST_BUSY, 3'd0},     // empty name
    '{ROW_REG, REG_NAME_FIRST + 3'd3, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, ST_BUSY, 3'd0},
    '{ROW_REG, REG_NAME_FIRST + 3'd4, 64'h61, 1'b0, ST_BUSY, 3'd0},    // "a"
    '{ROW_REG, REG_NAME_FIRST + 3'd5, 64'h78, 1'b0, ST_BUSY, 3'd0},    // "x"
    // leading spaces, duplicate names, line end past the length threshold
    '{ROW_CHAR, '0, 64'h20, 1'b1, ST_BUSY, 3'd0},
    '{ROW_CHAR, '0, 64'h20, 1'b1, ST_BUSY, 3'd0},
    '{ROW_CHAR, '0, 64'h61, 1'b1, ST_BUSY, 3'd0},
    '{ROW_CHAR, '0, 64'h62, 1'b1, ST_BUSY, 3'd0},
    '{ROW_CHAR, '0, 64'h0A, 1'b1, ST_MATCHED, 3'd0},
    // CR inside a line is not stored
    '{ROW_CHAR, '0, 64'h78, 1'b0, ST_BUSY, 3'd0},
    '{ROW_CHAR, '0, 64'h0D, 1'b0, ST_BUSY, 3'd0},
    '{ROW_CHAR, '0, 64'h0A, 1'b1, ST_MATCHED, 3'd5},
    // empty token hits the empty name
    '{ROW_CHAR, '0, 64'h0A, 1'b1, ST_MATCHED, 3'd2},
    // zero byte in the token never matches
    '{ROW_CHAR, '0, 64'h00, 1'b0, ST_BUSY, 3'd0},
    '{ROW_CHAR, '0, 64'h0A, 1'b1, ST_NOT_CMD, 3'd0},
    // overflow drops the byte and clears the line
    '{ROW_CHAR, '0, 64'h61, 1'b0, ST_BUSY, 3'd0},
    '{ROW_CHAR, '0, 64'h62, 1'b0, ST_BUSY, 3'd0},
    '{ROW_CHAR, '0, 64'h63, 1'b0, ST_BUSY, 3'd0},
    '{ROW_CHAR, '0, 64'h64, 1'b0, ST_BUSY, 3'd0},
    '{ROW_CHAR, '0, 64'h65, 1'b1, ST_MAX_SIZE, 3'd0},
    '{ROW_CHAR, '0, 64'h0A, 1'b1, ST_MATCHED, 3'd2},
    // smallest length limit
    '{ROW_REG, REG_MAX_LENGTH, 64'd0, 1'b0, ST_BUSY, 3'd0},
    '{ROW_CHAR, '0, 64'h61, 1'b0, ST_BUSY, 3'd0},
    '{ROW_CHAR, '0, 64'h62, 1'b1, ST_MAX_SIZE, 3'd0},
    '{ROW_CHAR, '0, 64'h0A, 1'b1, ST_MATCHED, 3'd2},
    // largest length limit, all-ones byte
    '{ROW_REG, REG_MAX_LENGTH, 64'd1023, 1'b0, ST_BUSY, 3'd0},
    '{ROW_CHAR, '0, 64'hFF, 1'b0, ST_BUSY, 3'd0},
    '{ROW_CHAR, '0, 64'h20, 1'b0, ST_BUSY, 3'd0},
    '{ROW_CHAR, '0, 64'h0A, 1'b0, ST_BUSY, 3'd0}
  };

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic [7:0]             in_rx_byte;
  logic                   out_valid;
  logic                   out_ready;
  logic [1:0]             out_status;
  logic [IndexW-1:0]      out_command_index;
  logic                   cfg_we;
  logic [RegIndexW-1:0]   cfg_index;
  logic [NameW-1:0]       cfg_data;

  int send_idle_pct = 8;
  int recv_idle_pct = 81;
  int fail_count    = 0;
  int cycle_count   = 0;
  int words_sent    = 0;

  line_status_t pending_status_q [$];

  // Predictor copy of the registers and the line state
  logic [MaxLenW-1:0]     cfg_max_len;
  logic [CmdCountW-1:0]   cfg_cmd_count;
  logic [NameW-1:0]       cfg_names [TableEntries];
  logic [StoredW-1:0]     line_count;
  token_phase_t           token_phase;
  logic [WordLenW-1:0]    token_len;
  logic [TableEntries-1:0] cand_mask;

  serial_command_word_matcher i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_command_index (out_command_index),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Stall the result channel at random
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Compare each taken result with the oldest pending status
  always @(posedge clk) begin
    line_status_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_status_q.size() == 0) begin
        $error("result with nothing pending: out_status %0d out_command_index %0d",
               out_status, out_command_index);
        fail_count++;
      end else begin
        want = pending_status_q.pop_front();
        if (out_status !== want.st) begin
          $error("out_status: expected %0d, got %0d", want.st, out_status);
          fail_count++;
        end
        if (out_command_index !== want.idx) begin
          $error("out_command_index: expected %0d, got %0d", want.idx, out_command_index);
          fail_count++;
        end
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("serial_command_word_matcher regression: fail");
      $finish;
    end
  end

  function automatic void clear_line_state();
    line_count  = '0;
    token_phase = PH_LEAD;
    token_len   = '0;
    cand_mask   = '1;
  endfunction

  // Narrow the candidates with one more token character
  function automatic void take_token_char(input logic [7:0] c);
    int i;
    for (i = 0; i < TableEntries; i++) begin
      if (token_len >= NameChars || c == CH_NUL ||
          cfg_names[i][8*int'(token_len[2:0]) +: 8] != c)
        cand_mask[i] = 1'b0;
    end
    if (token_len < NameChars + 1)
      token_len++;
  endfunction

  // Advance the line state by one byte and return its status
  function automatic line_status_t predict_line_status(input logic [7:0] c);
    line_status_t res;
    int n;
    int i;
    logic hit;
    res.st  = ST_BUSY;
    res.idx = '0;
    if (c == CH_LF) begin
      n = (cfg_cmd_count > TableEntries) ? TableEntries : int'(cfg_cmd_count);
      res.st = ST_NOT_CMD;
      for (i = 0; i < n; i++) begin
        hit = cand_mask[i];
        if (hit) begin
          if (token_len >= NameChars)
            hit = (token_len == NameChars);
          else
            hit = (cfg_names[i][8*int'(token_len[2:0]) +: 8] == CH_NUL);
        end
        if (hit && res.st != ST_MATCHED) begin
          res.st  = ST_MATCHED;
          res.idx = IndexW'(i);
        end
      end
      clear_line_state();
    end else if (line_count > cfg_max_len) begin
      clear_line_state();
      res.st = ST_MAX_SIZE;
    end else if (c != CH_CR) begin
      line_count++;
      unique case (token_phase)
        PH_LEAD: begin
          if (c != CH_SPACE) begin
            token_phase = PH_WORD;
            take_token_char(c);
          end
        end
        PH_WORD: begin
          if (c == CH_SPACE)
            token_phase = PH_DONE;
          else
            take_token_char(c);
        end
        default: ;
      endcase
    end
    return res;
  endfunction

  // Offer one word, wait for the handshake, then queue its status
  task automatic send_word(input logic [7:0] ch, input logic fixed, input line_status_t typed);
    line_status_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    in_rx_byte <= ch;
    do @(posedge clk); while (!in_ready);
    predicted = predict_line_status(ch);
    pending_status_q = {pending_status_q, (fixed ? typed : predicted)};
    words_sent++;
  endtask

  // Drop valid and hold until every pending status is back
  task automatic drain_line_status();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_status_q.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(input logic [RegIndexW-1:0] idx, input logic [NameW-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    unique case (idx)
      REG_MAX_LENGTH:    cfg_max_len = data[MaxLenW-1:0];
      REG_COMMAND_COUNT: cfg_cmd_count = data[CmdCountW-1:0];
      default:           cfg_names[idx - REG_NAME_FIRST] = data;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    directed_row_t    row;
    line_status_t     typed;
    logic [NameW-1:0] nm;
    logic [7:0]       line_q [$];
    logic [7:0]       token_q [$];
    int               p;
    int               i;
    int               k;
    int               n;
    int               m;
    int               e;
    int               phase_end;

    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_rx_byte = '0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;

    cfg_max_len   = MAX_LENGTH_RESET;
    cfg_cmd_count = '0;
    for (i = 0; i < TableEntries; i++)
      cfg_names[i] = '0;
    clear_line_state();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Walk the directed table
    foreach (DIRECTED_ROWS[r]) begin
      row = DIRECTED_ROWS[r];
      if (row.kind == ROW_REG) begin
        drain_line_status();
        write_reg(row.reg_idx, row.data);
      end else begin
        typed.st  = row.st;
        typed.idx = row.idx;
        send_word(row.data[7:0], row.fixed, typed);
      end
    end

    // Random lines, one table setting and one idle mode per phase
    for (p = 0; p < RANDOM_PHASES; p++) begin
      send_idle_pct = (p < 2) ? 8 : (p < 4) ? 81 : 0;
      recv_idle_pct = (p < 2) ? 81 : (p < 4) ? 8 : 0;
      drain_line_status();

      unique case (p)
        0:       write_reg(REG_MAX_LENGTH, 64'd20);
        1:       write_reg(REG_MAX_LENGTH, 64'd1023);
        2:       write_reg(REG_MAX_LENGTH, 64'd6);
        3:       write_reg(REG_MAX_LENGTH, 64'd0);
        4:       write_reg(REG_MAX_LENGTH, NameW'($urandom_range(0, 1023)));
        default: write_reg(REG_MAX_LENGTH, 64'd40);
      endcase
      write_reg(REG_COMMAND_COUNT, (p == 2) ? NameW'(TableEntries) :
                                              NameW'($urandom_range(0, 7)));

      // Mostly short names over a tiny alphabet, so prefixes and repeats are common
      for (i = 0; i < TableEntries; i++) begin
        m = $urandom_range(0, 9);
        if (m == 0) begin
          nm = {$urandom, $urandom};
        end else if (m == 1 && i > 0) begin
          nm = cfg_names[$urandom_range(0, i - 1)];
        end else begin
          nm = '0;
          n  = $urandom_range(0, NameChars);
          for (k = 0; k < n; k++)
            nm[8*k +: 8] = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(8'h61, 8'h64)) :
                                                          8'($urandom_range(1, 255));
        end
        write_reg(REG_NAME_FIRST + RegIndexW'(i), nm);
      end

      phase_end = words_sent + WORDS_PER_PHASE;
      while (words_sent < phase_end) begin
        line_q  = {};
        token_q = {};
        if ($urandom_range(0, 9) == 0) begin
          // raw noise
          n = $urandom_range(1, 12);
          repeat (n) line_q = {line_q, 8'($urandom_range(0, 255))};
        end else begin
          // leading spaces, a table name with an occasional flaw, arguments, line end
          repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0)
            line_q = {line_q, CH_SPACE};
          e = $urandom_range(0, TableEntries - 1);
          for (k = 0; k < NameChars && cfg_names[e][8*k +: 8] != CH_NUL; k++)
            token_q = {token_q, cfg_names[e][8*k +: 8]};
          m = $urandom_range(0, 7);
          if (m == 0 && token_q.size() > 0)
            void'(token_q.pop_back());
          else if (m == 1)
            token_q = {token_q, 8'($urandom_range(8'h61, 8'h64))};
          else if (m == 2 && token_q.size() > 0)
            token_q[$urandom_range(0, token_q.size() - 1)] = 8'($urandom_range(0, 255));
          else if (m == 3)
            token_q.insert($urandom_range(0, token_q.size()), CH_CR);
          line_q = {line_q, token_q};
          if ($urandom_range(0, 1) != 0) begin
            line_q = {line_q, CH_SPACE};
            repeat ($urandom_range(0, 24)) line_q = {line_q, 8'($urandom_range(8'h21, 8'h7E))};
          end
          if ($urandom_range(0, 4) == 0)
            line_q = {line_q, CH_CR};
          if ($urandom_range(0, 9) != 0)
            line_q = {line_q, CH_LF};
        end
        foreach (line_q[j])
          send_word(line_q[j], 1'b0, '0);
      end
    end

    drain_line_status();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("serial_command_word_matcher regression: pass");
    else
      $display("serial_command_word_matcher regression: fail");
    $finish;
  end

endmodule
